>>> rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// shared widths, character codes and register indexes of the text console
// writer
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int POS_W      = 13;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = ATTR_W + CHAR_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK_ATTRIBUTE = 2'd1;

    localparam logic [ATTR_W-1:0] BLANK_ATTR_RESET = 8'd7;

    typedef logic [POS_W-1:0] pos_t;

endpackage

>>> rtl/core/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_if
// word channels of the text console writer: characters in, positions out,
// register writes
// ----------------------------------------------------------------------------
interface tcw_char_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::CHAR_W-1:0]  char_code;
    logic [tcw_pkg::ATTR_W-1:0]  attribute;

    modport source (output valid, output char_code, output attribute, input ready);
    modport sink   (input valid, input char_code, input attribute, output ready);
endinterface

interface tcw_pos_if;
    logic          valid;
    logic          ready;
    tcw_pkg::pos_t cursor_position;
    tcw_pkg::pos_t display_start;

    modport source (output valid, output cursor_position, output display_start, input ready);
    modport sink   (input valid, input cursor_position, input display_start, output ready);
endinterface

interface tcw_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tcw_pkg::CFG_IDX_W-1:0]   reg_index;
    logic [tcw_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink   (input valid, input reg_index, input data, output ready);
endinterface

>>> rtl/core/tcw_col_rem.sv
// ----------------------------------------------------------------------------
// tcw_col_rem
// remainder of a cell distance by the column count, quotient from a reciprocal
// multiply registered first and the remainder registered from it after that
// ----------------------------------------------------------------------------
module tcw_col_rem #(
    parameter int COLUMNS = 80
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  tcw_pkg::pos_t              dividend,
    output logic                       done,
    output logic [$clog2(COLUMNS):0]   rem
);

    localparam int RW = $clog2(COLUMNS) + 1;
    localparam int PW = tcw_pkg::POS_W;
    localparam int SH = PW + $clog2(COLUMNS);
    localparam int QW = PW - 4;
    localparam int MW = SH + QW;
    localparam logic [MW-1:0] RECIP = MW'(((1 << SH) + COLUMNS - 1) / COLUMNS);

    logic [MW-1:0]       prod;
    logic [QW-1:0]       quot_reg;
    tcw_pkg::pos_t       dist_reg;
    tcw_pkg::pos_t       back;
    tcw_pkg::pos_t       diff;
    logic [RW-1:0]       rem_reg;
    logic                busy_reg;
    logic                done_reg;

    assign prod = MW'(dividend) * RECIP;
    assign back = PW'(quot_reg) * PW'(COLUMNS);
    assign diff = dist_reg - back;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_reg <= '0;
            dist_reg <= '0;
            rem_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
            done_reg <= busy_reg;
            if (start)
            begin
                quot_reg <= prod[MW-1:SH];
                dist_reg <= dividend;
            end
            if (busy_reg)
            begin
                rem_reg <= diff[RW-1:0];
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

>>> rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// writes characters into a text cell store, keeping cursor and display start
// ----------------------------------------------------------------------------
// After reset the cell store is cleared, one cell a cycle, and no character is
// taken until it is done (register writes are taken at once). A printable
// character or a backspace then goes through the write and check steps to
// its position word, and a newline through the remainder unit and the check
// step. The remainder unit forms the quotient of the cursor distance by
// COLUMNS with a reciprocal multiply and then registers the remainder. The
// block takes a new character only when the previous one is finished. When
// the cursor reaches two screens past the base, the screen copy and blanking
// run through the single store write port. A position word not yet taken
// waits in the output register, and the block holds in its last step until
// it is free.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLUMNS     = 80,
    parameter int ROWS        = 25,
    parameter int STORE_CELLS = 8192
) (
    input  logic       clk,
    input  logic       rst_n,
    tcw_cfg_if.sink    cfg,
    tcw_char_if.sink   char_in,
    tcw_pos_if.source  pos_out
);

    localparam int SCREEN = COLUMNS * ROWS;
    localparam int AW     = $clog2(STORE_CELLS);
    localparam int CW     = $clog2(SCREEN);
    localparam int RW     = $clog2(COLUMNS) + 1;
    localparam int PW     = tcw_pkg::POS_W;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_WRITE = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_CP_RD = 4'd5;
    localparam logic [3:0] S_CP_WR = 4'd6;
    localparam logic [3:0] S_BLANK = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0]                     state_reg;
    tcw_pkg::pos_t                  cursor_reg;
    tcw_pkg::pos_t                  start_reg;
    tcw_pkg::pos_t                  base_reg;
    logic [tcw_pkg::ATTR_W-1:0]     blank_attr_reg;
    logic [tcw_pkg::CHAR_W-1:0]     ch_reg;
    logic [tcw_pkg::ATTR_W-1:0]     attr_reg;
    logic                           neg_reg;
    logic [AW-1:0]                  src_reg;
    logic [AW-1:0]                  dst_reg;
    logic [CW-1:0]                  cnt_reg;
    logic                           out_valid_reg;
    tcw_pkg::pos_t                  out_cursor_reg;
    tcw_pkg::pos_t                  out_start_reg;

    logic [tcw_pkg::CELL_W-1:0]     cell_mem [STORE_CELLS];
    logic [tcw_pkg::CELL_W-1:0]     rdata_reg;
    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]     mem_wdata;

    logic                           accept;
    logic                           out_free;
    logic                           rem_start;
    tcw_pkg::pos_t                  rem_dividend;
    logic                           rem_done;
    logic [RW-1:0]                  rem_value;
    logic [31:0]                    col_step;
    tcw_pkg::pos_t                  nl_cursor;
    tcw_pkg::pos_t                  fin_start;
    logic                           wrap_hit;

    function automatic logic [AW-1:0] cell_idx(input tcw_pkg::pos_t pos);
        logic [31:0] p;
        p = 32'(pos);
        if (p >= 32'(STORE_CELLS))
        begin
            p = p - 32'(STORE_CELLS);
        end
        return p[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        r = a + AW'(1);
        if (a == AW'(STORE_CELLS - 1))
        begin
            r = '0;
        end
        return r;
    endfunction

    assign accept       = char_in.valid && char_in.ready;
    assign out_free     = !out_valid_reg || pos_out.ready;
    assign rem_start    = accept && (char_in.char_code == tcw_pkg::CH_NEWLINE);
    assign rem_dividend = (cursor_reg < base_reg) ? (base_reg - cursor_reg)
                                                  : (cursor_reg - base_reg);

    tcw_col_rem #(
        .COLUMNS (COLUMNS)
    ) u_col_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (rem_dividend),
        .done     (rem_done),
        .rem      (rem_value)
    );

    // distance to the next line start
    always_comb
    begin
        col_step = 32'(COLUMNS) - 32'(rem_value);
        if (neg_reg)
        begin
            col_step = (rem_value == '0) ? 32'(COLUMNS) : 32'(rem_value);
        end
        nl_cursor = PW'(32'(cursor_reg) + col_step);
    end

    assign wrap_hit  = 32'(cursor_reg) >= 32'(base_reg) + 32'(2 * SCREEN);
    assign fin_start = (32'(cursor_reg) >= 32'(start_reg) + 32'(SCREEN))
                       ? PW'(32'(start_reg) + 32'(COLUMNS)) : start_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = src_reg;
        mem_wdata = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
            end
            S_WRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = cell_idx(cursor_reg);
                mem_wdata = {attr_reg, (ch_reg == tcw_pkg::CH_BACKSPACE)
                                       ? tcw_pkg::CH_SPACE : ch_reg};
            end
            S_CP_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = dst_reg;
                mem_wdata = rdata_reg;
            end
            S_BLANK:
            begin
                mem_we    = 1'b1;
                mem_wdata = {blank_attr_reg, tcw_pkg::CHAR_W'(0)};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= cell_mem[src_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg   <= char_in.char_code;
            attr_reg <= char_in.attribute;
            neg_reg  <= cursor_reg < base_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= '0;
            blank_attr_reg <= tcw_pkg::BLANK_ATTR_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.reg_index)
                tcw_pkg::REG_BASE_OFFSET:
                begin
                    base_reg <= cfg.data;
                end
                tcw_pkg::REG_BLANK_ATTRIBUTE:
                begin
                    blank_attr_reg <= cfg.data[tcw_pkg::ATTR_W-1:0];
                end
                default:
                begin
                    base_reg <= base_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cursor_reg    <= '0;
            start_reg     <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && pos_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    src_reg <= addr_inc(src_reg);
                    if (src_reg == AW'(STORE_CELLS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (char_in.char_code == tcw_pkg::CH_NEWLINE)
                        begin
                            state_reg <= S_MOD;
                        end
                        else
                        begin
                            if (char_in.char_code == tcw_pkg::CH_BACKSPACE
                                && cursor_reg > base_reg)
                            begin
                                cursor_reg <= cursor_reg - PW'(1);
                            end
                            state_reg <= S_WRITE;
                        end
                    end
                end
                S_MOD:
                begin
                    if (rem_done)
                    begin
                        cursor_reg <= nl_cursor;
                        state_reg  <= S_CHECK;
                    end
                end
                S_WRITE:
                begin
                    if (ch_reg != tcw_pkg::CH_BACKSPACE)
                    begin
                        cursor_reg <= cursor_reg + PW'(1);
                    end
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (wrap_hit)
                    begin
                        src_reg   <= cell_idx(start_reg);
                        dst_reg   <= cell_idx(base_reg);
                        cnt_reg   <= '0;
                        state_reg <= S_CP_RD;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_CP_RD:
                begin
                    state_reg <= S_CP_WR;
                end
                S_CP_WR:
                begin
                    dst_reg <= addr_inc(dst_reg);
                    if (cnt_reg == CW'(SCREEN - 1))
                    begin
                        src_reg   <= cell_idx(start_reg);
                        cnt_reg   <= '0;
                        state_reg <= S_BLANK;
                    end
                    else
                    begin
                        src_reg   <= addr_inc(src_reg);
                        cnt_reg   <= cnt_reg + CW'(1);
                        state_reg <= S_CP_RD;
                    end
                end
                S_BLANK:
                begin
                    src_reg <= addr_inc(src_reg);
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(SCREEN - 1))
                    begin
                        cursor_reg <= PW'(32'(base_reg) + 32'(SCREEN));
                        start_reg  <= base_reg;
                        state_reg  <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        start_reg <= fin_start;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN && out_free)
        begin
            out_cursor_reg <= cursor_reg;
            out_start_reg  <= fin_start;
        end
    end

    assign cfg.ready               = 1'b1;
    assign char_in.ready           = (state_reg == S_IDLE);
    assign pos_out.valid           = out_valid_reg;
    assign pos_out.cursor_position = out_cursor_reg;
    assign pos_out.display_start   = out_start_reg;

endmodule
